/* rtl/tcrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrp_pkg
// Shared types and constants for the CertificateRequest parser.
// ----------------------------------------------------------------------------
package tcrp_pkg;

  localparam int LEN_BITS = 16;
  localparam int CW       = (LEN_BITS > 16) ? LEN_BITS + 1 : 17;
  localparam int ALG_SIZE = 2;
  localparam int EXT_HDR  = 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_IW    = $clog2(Q_DEPTH);

  localparam logic [1:0] MODE_TLS12 = 2'd0;
  localparam logic [1:0] MODE_TLCP  = 2'd1;
  localparam logic [1:0] MODE_TLS13 = 2'd2;

  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_SIG_TYPE = 2'd1;

  localparam logic [1:0]  MODE_RESET     = MODE_TLS12;
  localparam logic [15:0] SIG_TYPE_RESET = 16'd13;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_DONE    = 4'd1,
    PH_CT_LEN  = 4'd2,
    PH_CT      = 4'd3,
    PH_SA_HI   = 4'd4,
    PH_SA_LO   = 4'd5,
    PH_SA_LIST = 4'd6,
    PH_CTX_LEN = 4'd7,
    PH_CTX     = 4'd8,
    PH_EL_HI   = 4'd9,
    PH_EL_LO   = 4'd10,
    PH_ET_HI   = 4'd11,
    PH_ET_LO   = 4'd12,
    PH_EX_HI   = 4'd13,
    PH_EX_LO   = 4'd14,
    PH_SKIP    = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CERT_TYPE = 2'd0,
    KIND_SIG_ALG   = 2'd1,
    KIND_CTX       = 2'd2,
    KIND_END       = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DECODE  = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] sig_type;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    status_t     status;
    logic        last;
  } res_t;

endpackage

/* rtl/tcrp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrp_core
// Parse state machine: takes one beat per cycle while step is high, returns up to two results.
// ----------------------------------------------------------------------------
module tcrp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                action,
  input  logic [15:0]         msg_length,
  input  logic [7:0]          msg_byte,
  input  tcrp_pkg::cfg_t      cfg,
  output logic [1:0]          push_cnt,
  output tcrp_pkg::res_t      res0,
  output tcrp_pkg::res_t      res1
);

  tcrp_pkg::phase_t phase, phase_next;
  logic [tcrp_pkg::LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic [15:0] field_left, field_left_next;
  logic [15:0] ext_left, ext_left_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [15:0] ext_kind, ext_kind_next;
  logic        seen_sig_algs, seen_sig_algs_next;

  logic tls13;
  logic byte_live;
  logic [tcrp_pkg::LEN_BITS-1:0] bl_dec;
  logic [15:0] el_dec;
  logic [15:0] fl_dec;
  logic [15:0] len16;
  logic [tcrp_pkg::CW-1:0] bl_w, len_w, b_w, room_w;
  logic [tcrp_pkg::LEN_BITS-1:0] start_len;
  logic in_ext_phase;
  logic nx_fin;
  tcrp_pkg::status_t nx_status;

  logic fin;
  tcrp_pkg::status_t fin_status;
  logic data_put;
  tcrp_pkg::kind_t data_kind;
  logic [15:0] data_value;
  tcrp_pkg::res_t data_res, fin_res;

  assign tls13     = (cfg.mode == tcrp_pkg::MODE_TLS13);
  assign byte_live = step && action && (phase != tcrp_pkg::PH_IDLE) &&
                     (phase != tcrp_pkg::PH_DONE) && (bytes_left != '0);
  assign bl_dec    = bytes_left - 1'b1;
  assign fl_dec    = field_left - 16'd1;
  assign len16     = {held_byte, msg_byte};
  assign start_len = tcrp_pkg::LEN_BITS'(msg_length);

  assign in_ext_phase = (phase == tcrp_pkg::PH_SA_HI) || (phase == tcrp_pkg::PH_SA_LO) ||
                        (phase == tcrp_pkg::PH_SA_LIST) || (phase == tcrp_pkg::PH_SKIP);
  assign el_dec = (tls13 && in_ext_phase && (ext_left != 16'd0)) ? ext_left - 16'd1 : ext_left;

  assign bl_w   = tcrp_pkg::CW'(bl_dec);
  assign len_w  = tcrp_pkg::CW'(len16);
  assign b_w    = tcrp_pkg::CW'(msg_byte);
  assign room_w = tls13 ? tcrp_pkg::CW'(el_dec) : bl_w;

  // next extension header, or end of the list
  assign nx_fin    = (bl_w < tcrp_pkg::CW'(tcrp_pkg::EXT_HDR));
  assign nx_status = (bl_dec == '0) ? tcrp_pkg::ST_OK : tcrp_pkg::ST_DECODE;

  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    field_left_next    = field_left;
    ext_left_next      = ext_left;
    held_byte_next     = held_byte;
    ext_kind_next      = ext_kind;
    seen_sig_algs_next = seen_sig_algs;
    fin                = 1'b0;
    fin_status         = tcrp_pkg::ST_OK;
    if (step && !action) begin
      bytes_left_next    = start_len;
      field_left_next    = '0;
      ext_left_next      = '0;
      held_byte_next     = '0;
      ext_kind_next      = '0;
      seen_sig_algs_next = 1'b0;
      if (start_len == '0) begin
        fin        = 1'b1;
        fin_status = tcrp_pkg::ST_DECODE;
      end else begin
        phase_next = tls13 ? tcrp_pkg::PH_CTX_LEN : tcrp_pkg::PH_CT_LEN;
      end
    end else if (step && action && (phase != tcrp_pkg::PH_IDLE) &&
                 (phase != tcrp_pkg::PH_DONE) && (bytes_left == '0)) begin
      phase_next = tcrp_pkg::PH_DONE;
    end else if (byte_live) begin
      bytes_left_next = bl_dec;
      ext_left_next   = el_dec;
      unique case (phase)
        tcrp_pkg::PH_CT_LEN: begin
          if (msg_byte == 8'd0 || b_w > bl_w) begin
            fin        = 1'b1;
            fin_status = tcrp_pkg::ST_DECODE;
          end else begin
            field_left_next = 16'(msg_byte);
            phase_next      = tcrp_pkg::PH_CT;
          end
        end
        tcrp_pkg::PH_CT: begin
          field_left_next = fl_dec;
          if (fl_dec == 16'd0) begin
            if (cfg.mode == tcrp_pkg::MODE_TLCP) begin
              fin = 1'b1;
            end else if (bl_w < tcrp_pkg::CW'(tcrp_pkg::ALG_SIZE)) begin
              fin        = 1'b1;
              fin_status = tcrp_pkg::ST_DECODE;
            end else begin
              phase_next = tcrp_pkg::PH_SA_HI;
            end
          end
        end
        tcrp_pkg::PH_SA_HI: begin
          held_byte_next = msg_byte;
          phase_next     = tcrp_pkg::PH_SA_LO;
        end
        tcrp_pkg::PH_SA_LO: begin
          if (len_w > room_w || len16[0] || len16 == 16'd0) begin
            fin        = 1'b1;
            fin_status = tcrp_pkg::ST_DECODE;
          end else begin
            field_left_next    = len16;
            seen_sig_algs_next = 1'b1;
            phase_next         = tcrp_pkg::PH_SA_LIST;
          end
        end
        tcrp_pkg::PH_SA_LIST: begin
          field_left_next = fl_dec;
          if (fl_dec[0]) begin
            held_byte_next = msg_byte;
          end
          if (fl_dec == 16'd0) begin
            if (!tls13) begin
              fin = 1'b1;
            end else if (el_dec != 16'd0) begin
              phase_next = tcrp_pkg::PH_SKIP;
            end else if (nx_fin) begin
              fin        = 1'b1;
              fin_status = nx_status;
            end else begin
              phase_next = tcrp_pkg::PH_ET_HI;
            end
          end
        end
        tcrp_pkg::PH_CTX_LEN: begin
          if (b_w + tcrp_pkg::CW'(2) > bl_w) begin
            fin        = 1'b1;
            fin_status = tcrp_pkg::ST_DECODE;
          end else begin
            field_left_next = 16'(msg_byte);
            phase_next = (msg_byte == 8'd0) ? tcrp_pkg::PH_EL_HI : tcrp_pkg::PH_CTX;
          end
        end
        tcrp_pkg::PH_CTX: begin
          field_left_next = fl_dec;
          if (fl_dec == 16'd0) begin
            phase_next = tcrp_pkg::PH_EL_HI;
          end
        end
        tcrp_pkg::PH_EL_HI, tcrp_pkg::PH_ET_HI, tcrp_pkg::PH_EX_HI: begin
          held_byte_next = msg_byte;
          phase_next     = tcrp_pkg::phase_t'(phase + 4'd1);
        end
        tcrp_pkg::PH_EL_LO: begin
          if (len_w != bl_w || len16 == 16'd0) begin
            fin        = 1'b1;
            fin_status = tcrp_pkg::ST_DECODE;
          end else if (nx_fin) begin
            fin        = 1'b1;
            fin_status = nx_status;
          end else begin
            phase_next = tcrp_pkg::PH_ET_HI;
          end
        end
        tcrp_pkg::PH_ET_LO: begin
          ext_kind_next = len16;
          phase_next    = tcrp_pkg::PH_EX_HI;
        end
        tcrp_pkg::PH_EX_LO: begin
          if (len_w > bl_w) begin
            fin        = 1'b1;
            fin_status = tcrp_pkg::ST_DECODE;
          end else begin
            ext_left_next = len16;
            if (ext_kind == cfg.sig_type) begin
              if (seen_sig_algs) begin
                fin        = 1'b1;
                fin_status = tcrp_pkg::ST_ILLEGAL;
              end else if (len16 < 16'(tcrp_pkg::ALG_SIZE)) begin
                fin        = 1'b1;
                fin_status = tcrp_pkg::ST_DECODE;
              end else begin
                phase_next = tcrp_pkg::PH_SA_HI;
              end
            end else if (len16 == 16'd0) begin
              if (nx_fin) begin
                fin        = 1'b1;
                fin_status = nx_status;
              end else begin
                phase_next = tcrp_pkg::PH_ET_HI;
              end
            end else begin
              phase_next = tcrp_pkg::PH_SKIP;
            end
          end
        end
        tcrp_pkg::PH_SKIP: begin
          if (el_dec == 16'd0) begin
            if (nx_fin) begin
              fin        = 1'b1;
              fin_status = nx_status;
            end else begin
              phase_next = tcrp_pkg::PH_ET_HI;
            end
          end
        end
        default: begin
          phase_next = tcrp_pkg::PH_DONE;
        end
      endcase
    end
    if (fin) begin
      phase_next = tcrp_pkg::PH_DONE;
    end
  end

  always_comb begin
    data_put   = 1'b0;
    data_kind  = tcrp_pkg::KIND_CERT_TYPE;
    data_value = 16'(msg_byte);
    if (byte_live) begin
      unique case (phase)
        tcrp_pkg::PH_CT: begin
          data_put = 1'b1;
        end
        tcrp_pkg::PH_SA_LIST: begin
          data_put   = !fl_dec[0];
          data_kind  = tcrp_pkg::KIND_SIG_ALG;
          data_value = len16;
        end
        tcrp_pkg::PH_CTX: begin
          data_put  = 1'b1;
          data_kind = tcrp_pkg::KIND_CTX;
        end
        default: begin
          data_put = 1'b0;
        end
      endcase
    end
    data_res = '{kind: data_kind, value: data_value, status: tcrp_pkg::ST_OK, last: 1'b0};
    fin_res  = '{kind: tcrp_pkg::KIND_END, value: 16'd0, status: fin_status, last: 1'b1};
    res0     = data_put ? data_res : fin_res;
    res1     = fin_res;
    push_cnt = 2'(data_put) + 2'(fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tcrp_pkg::PH_IDLE;
      bytes_left    <= '0;
      field_left    <= '0;
      ext_left      <= '0;
      held_byte     <= '0;
      ext_kind      <= '0;
      seen_sig_algs <= 1'b0;
    end else begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      field_left    <= field_left_next;
      ext_left      <= ext_left_next;
      held_byte     <= held_byte_next;
      ext_kind      <= ext_kind_next;
      seen_sig_algs <= seen_sig_algs_next;
    end
  end

  a_fin_goes_done: assert property (@(posedge clk) disable iff (rst)
    (step && fin) |=> (phase == tcrp_pkg::PH_DONE))
    else $error("finish did not close the message");

  a_second_is_end: assert property (@(posedge clk) disable iff (rst)
    (push_cnt == 2'd2) |-> (res1.kind == tcrp_pkg::KIND_END && res1.last &&
                            res0.kind != tcrp_pkg::KIND_END))
    else $error("two results without data then end status");

endmodule

/* rtl/tls_cert_request_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_cert_request_parser
// Results are registered in the result queue before they reach the output.
// Throughput: one input beat per cycle while in_stall is low; a beat that yields a
// data result and the end status pushes two results, absorbed by a 4-entry result queue.
// in_stall rises while the queue has fewer than two free entries.
// Reset (rst, synchronous): parser idle, queue empty, mode TLS1.2, type 13.
// ----------------------------------------------------------------------------
module tls_cert_request_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] msg_length,
  input  logic [7:0]  msg_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] value,
  output logic [1:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tcrp_pkg::cfg_t cfg;
  logic           step;
  logic [1:0]     push_cnt;
  tcrp_pkg::res_t res0, res1;

  tcrp_pkg::res_t q      [tcrp_pkg::Q_DEPTH];
  tcrp_pkg::res_t q_next [tcrp_pkg::Q_DEPTH];
  logic [tcrp_pkg::Q_IW:0] q_cnt, q_cnt_next, base, base1;
  logic pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= tcrp_pkg::MODE_RESET;
      cfg.sig_type <= tcrp_pkg::SIG_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcrp_pkg::CFG_MODE:     cfg.mode     <= cfg_data[1:0];
        tcrp_pkg::CFG_SIG_TYPE: cfg.sig_type <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (q_cnt > (tcrp_pkg::Q_IW + 1)'(tcrp_pkg::Q_DEPTH - 2));
  assign step     = in_valid && !in_stall;

  tcrp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .action     (action),
    .msg_length (msg_length),
    .msg_byte   (msg_byte),
    .cfg        (cfg),
    .push_cnt   (push_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  // result queue: head at entry 0, shifts down on each popped result
  assign out_valid = (q_cnt != '0);
  assign pop       = out_valid && !out_stall;
  assign base      = q_cnt - (tcrp_pkg::Q_IW + 1)'(pop);
  assign base1     = base + 1'b1;

  always_comb begin
    for (int i = 0; i < tcrp_pkg::Q_DEPTH; i++) begin
      if (pop && i < tcrp_pkg::Q_DEPTH - 1) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (push_cnt != 2'd0 && base[tcrp_pkg::Q_IW-1:0] == tcrp_pkg::Q_IW'(i)) begin
        q_next[i] = res0;
      end
      if (push_cnt == 2'd2 && base1[tcrp_pkg::Q_IW-1:0] == tcrp_pkg::Q_IW'(i)) begin
        q_next[i] = res1;
      end
    end
    q_cnt_next = base + (tcrp_pkg::Q_IW + 1)'(push_cnt);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt_next;
    end
  end

  assign kind   = q[0].kind;
  assign value  = q[0].value;
  assign status = q[0].status;
  assign last   = q[0].last;

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= (tcrp_pkg::Q_IW + 1)'(tcrp_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_zero_len_end: assert property (@(posedge clk) disable iff (rst)
    (step && !action && msg_length == 16'd0) |=> out_valid)
    else $error("zero length start gave no result");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_cnt != 2'd0) |-> (step && base < (tcrp_pkg::Q_IW + 1)'(tcrp_pkg::Q_DEPTH - 1)))
    else $error("result pushed without room or without a beat");

endmodule
